[src/pcd_pkg.sv]
// Shared types, constants and functions of the PNG chunk deframer.
// No dependencies; imported by the deframer and its testbench.
package pcd_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LENGTH       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_TYPE_LETTERS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_CRC          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_FLAG_ONLY      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_DATA          = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// crc status of a summary
	localparam logic [1:0] CRC_MISMATCH    = 2'd0;
	localparam logic [1:0] CRC_MATCH       = 2'd1;
	localparam logic [1:0] CRC_NOT_CHECKED = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE = 3'd1;
	localparam logic [2:0] ERR_LENGTH    = 3'd2;
	localparam logic [2:0] ERR_TYPE_CHAR = 3'd3;
	localparam logic [2:0] ERR_CRC       = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;

	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [31:0] IEND_TYPE = 32'h4945_4E44;

	typedef enum logic [4:0] {
		PH_SIG  = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_TYPE = 5'b00100,
		PH_DATA = 5'b01000,
		PH_CRC  = 5'b10000
	} phase_t;

	// PNG file signature, byte by position
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			3'd7: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
	endfunction

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[src/pcd_in_if.sv]
// Input stream channel of the PNG chunk deframer: one file byte per beat.
// Depends on nothing but the valid/ready convention.
interface pcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

[src/pcd_out_if.sv]
// Result channel of the PNG chunk deframer: data byte, chunk summary or error.
// Depends on nothing but the valid/ready convention.
interface pcd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  out_byte;
	logic [31:0] chunk_length;
	logic [31:0] chunk_tag;
	logic [1:0]  crc_status;
	logic        is_end_chunk;
	logic [2:0]  error_code;

	modport source (output valid, output result_kind, output out_byte, output chunk_length,
		output chunk_tag, output crc_status, output is_end_chunk, output error_code,
		input ready);
	modport sink   (input valid, input result_kind, input out_byte, input chunk_length,
		input chunk_tag, input crc_status, input is_end_chunk, input error_code,
		output ready);
endinterface

[src/png_chunk_deframer.sv]
// PNG chunk deframer: signature check, chunk split, CRC-32 check, summaries.
// Each result is registered: it is valid in the cycle after the beat that causes it.
// Throughput: one input beat per cycle while the result register is empty or draining.
// Reset (arst_n low, asynchronous): signature phase, CRC all ones, not halted,
// options back to their defaults (all checks on, flag-only off, pass-through on).
// Depends on pcd_pkg, pcd_in_if and pcd_out_if.
module png_chunk_deframer
	import pcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	pcd_in_if.sink                stream,
	pcd_out_if.source             result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	// options
	logic chk_len_q, chk_type_q, chk_crc_q, flag_only_q, pass_data_q;

	// parser state
	phase_t      phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] len_q, len_d;
	logic [31:0] type_q, type_d;
	logic [31:0] rcrc_q, rcrc_d;
	logic [31:0] crc_q, crc_d;
	logic        halted_q, halted_d;

	// result register
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_byte_q;
	logic [31:0] out_len_q;
	logic [31:0] out_type_q;
	logic [1:0]  out_crcst_q;
	logic        out_iend_q;
	logic [2:0]  out_err_q;

	// next result
	logic        emit;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic [31:0] res_len;
	logic [31:0] res_type;
	logic [1:0]  res_crcst;
	logic        res_iend;
	logic [2:0]  res_err;

	logic        accept;
	logic [7:0]  b;
	logic [31:0] cnt_inc;
	logic [31:0] crc_upd;
	logic [31:0] len_shift, type_shift, rcrc_shift;

	// a beat goes in whenever the result register is empty or draining
	assign stream.ready = !out_valid_q || result.ready;
	assign accept       = stream.valid && stream.ready;

	assign b          = stream.in_byte;
	assign cnt_inc    = cnt_q + 32'd1;
	assign crc_upd    = crc_byte(crc_q, b);
	assign len_shift  = {len_q[23:0], b};
	assign type_shift = {type_q[23:0], b};
	assign rcrc_shift = {rcrc_q[23:0], b};

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		len_d     = len_q;
		type_d    = type_q;
		rcrc_d    = rcrc_q;
		crc_d     = crc_q;
		halted_d  = halted_q;
		emit      = 1'b0;
		res_kind  = KIND_DATA;
		res_byte  = 8'd0;
		res_len   = 32'd0;
		res_type  = 32'd0;
		res_crcst = CRC_MISMATCH;
		res_iend  = 1'b0;
		res_err   = ERR_NONE;

		if (!halted_q) begin
			if (stream.end_of_stream) begin
				// clean end only at a chunk boundary or before the first byte
				if (((phase_q == PH_SIG) || (phase_q == PH_LEN)) && (cnt_q == 32'd0)) begin
					phase_d = PH_SIG;
					cnt_d   = 32'd0;
					len_d   = 32'd0;
					type_d  = 32'd0;
					rcrc_d  = 32'd0;
					crc_d   = CRC_INIT;
				end else begin
					emit     = 1'b1;
					res_kind = KIND_ERROR;
					res_err  = ERR_TRUNCATED;
					halted_d = 1'b1;
				end
			end else begin
				case (phase_q)
					PH_SIG: begin
						if (b != sig_byte(cnt_q[2:0])) begin
							emit     = 1'b1;
							res_kind = KIND_ERROR;
							res_err  = ERR_SIGNATURE;
							halted_d = 1'b1;
						end else if (cnt_q[2:0] == 3'd7) begin
							phase_d = PH_LEN;
							cnt_d   = 32'd0;
							len_d   = 32'd0;
							type_d  = 32'd0;
							rcrc_d  = 32'd0;
							crc_d   = CRC_INIT;
						end else begin
							cnt_d = cnt_inc;
						end
					end
					PH_LEN: begin
						len_d = len_shift;
						cnt_d = cnt_inc;
						if (cnt_q[1:0] == 2'd3) begin
							if (chk_len_q && len_shift[31]) begin
								emit     = 1'b1;
								res_kind = KIND_ERROR;
								res_err  = ERR_LENGTH;
								halted_d = 1'b1;
							end else begin
								phase_d = PH_TYPE;
								cnt_d   = 32'd0;
							end
						end
					end
					PH_TYPE: begin
						if (chk_type_q && !is_letter(b)) begin
							emit     = 1'b1;
							res_kind = KIND_ERROR;
							res_err  = ERR_TYPE_CHAR;
							halted_d = 1'b1;
						end else begin
							type_d = type_shift;
							crc_d  = crc_upd;
							cnt_d  = cnt_inc;
							if (cnt_q[1:0] == 2'd3) begin
								// empty chunk: CRC follows the type directly
								phase_d = (len_q == 32'd0) ? PH_CRC : PH_DATA;
								cnt_d   = 32'd0;
							end
						end
					end
					PH_DATA: begin
						crc_d = crc_upd;
						if (cnt_inc >= len_q) begin
							phase_d = PH_CRC;
							cnt_d   = 32'd0;
						end else begin
							cnt_d = cnt_inc;
						end
						if (pass_data_q) begin
							emit     = 1'b1;
							res_kind = KIND_DATA;
							res_byte = b;
						end
					end
					PH_CRC: begin
						rcrc_d = rcrc_shift;
						cnt_d  = cnt_inc;
						if (cnt_q[1:0] == 2'd3) begin
							if (chk_crc_q && (~crc_q != rcrc_shift) && !flag_only_q) begin
								emit     = 1'b1;
								res_kind = KIND_ERROR;
								res_err  = ERR_CRC;
								halted_d = 1'b1;
							end else begin
								emit      = 1'b1;
								res_kind  = KIND_SUMMARY;
								res_len   = len_q;
								res_type  = type_q;
								res_iend  = (type_q == IEND_TYPE);
								if (!chk_crc_q) begin
									res_crcst = CRC_NOT_CHECKED;
								end else if (~crc_q == rcrc_shift) begin
									res_crcst = CRC_MATCH;
								end else begin
									res_crcst = CRC_MISMATCH;
								end
								// next chunk
								phase_d = PH_LEN;
								cnt_d   = 32'd0;
								len_d   = 32'd0;
								type_d  = 32'd0;
								rcrc_d  = 32'd0;
								crc_d   = CRC_INIT;
							end
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// options; only bit 0 of the data matters, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_len_q   <= 1'b1;
			chk_type_q  <= 1'b1;
			chk_crc_q   <= 1'b1;
			flag_only_q <= 1'b0;
			pass_data_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				CFG_CHECK_LENGTH:       chk_len_q   <= wr_data[0];
				CFG_CHECK_TYPE_LETTERS: chk_type_q  <= wr_data[0];
				CFG_CHECK_CRC:          chk_crc_q   <= wr_data[0];
				CFG_CRC_FLAG_ONLY:      flag_only_q <= wr_data[0];
				CFG_PASS_DATA:          pass_data_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// parser state advances once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			cnt_q    <= 32'd0;
			len_q    <= 32'd0;
			type_q   <= 32'd0;
			rcrc_q   <= 32'd0;
			crc_q    <= CRC_INIT;
			halted_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			type_q   <= type_d;
			rcrc_q   <= rcrc_d;
			crc_q    <= crc_d;
			halted_q <= halted_d;
		end
	end

	// result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_kind_q  <= res_kind;
			out_byte_q  <= res_byte;
			out_len_q   <= res_len;
			out_type_q  <= res_type;
			out_crcst_q <= res_crcst;
			out_iend_q  <= res_iend;
			out_err_q   <= res_err;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_kind  = out_kind_q;
	assign result.out_byte     = out_byte_q;
	assign result.chunk_length = out_len_q;
	assign result.chunk_tag    = out_type_q;
	assign result.crc_status   = out_crcst_q;
	assign result.is_end_chunk = out_iend_q;
	assign result.error_code   = out_err_q;

	// once halted, the parser stays halted until reset
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag dropped without reset");

	// an error beat on the output means the parser has halted
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_ERROR)) |-> halted_q)
		else $error("error result without halt");

	// signature counter stays inside the signature
	a_sig_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SIG) |-> (cnt_q < 32'd8))
		else $error("signature counter out of range");

	// four-byte fields never count past their last byte while parsing
	a_field_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!halted_q && ((phase_q == PH_LEN) || (phase_q == PH_TYPE) || (phase_q == PH_CRC)))
		|-> (cnt_q < 32'd4))
		else $error("field counter out of range");

	// no data phase for an empty chunk, and the data counter stays below the length
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (cnt_q < len_q))
		else $error("data counter reached chunk length");

endmodule

[tb/tb_png_chunk_deframer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for png_chunk_deframer: directed and random PNG byte streams.
// Depends on pcd_pkg, pcd_in_if, pcd_out_if and the deframer RTL.
module tb_png_chunk_deframer
	import pcd_pkg::*;
();

	// PNG signature, first byte in the top bits
	localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
	localparam logic [7:0] LOWER_A = "a";
	localparam logic [7:0] LOWER_Z = "z";
	localparam logic [7:0] UPPER_A = "A";
	localparam logic [7:0] UPPER_Z = "Z";
	localparam logic [7:0] CASE_BIT = 8'h20;
	// an index past the register list; the block must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int BEATS_PER_PHASE = 150;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} stream_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [31:0] length;
		logic [31:0] ctype;
		logic [1:0]  crc;
		logic        iend;
		logic [2:0]  err;
	} chunk_result_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	pcd_in_if  stream_if();
	pcd_out_if result_if();

	png_chunk_deframer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream_if),
		.result   (result_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	stream_beat_t  pending_beats[$];
	chunk_result_t expected_results[$];
	int mismatches;
	int queued_beats;
	// set for one phase: neither side idles while it is high
	bit calm;

	// shadow of the block: options
	bit chk_len, chk_letters, chk_crc, crc_flag, pass_bytes;
	// shadow of the block: parser state
	phase_t      ph;
	logic [31:0] cnt, len_r, typ_r, rcrc, ccrc;
	bit          halted;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shadow model
	// ---------------------------------------------------------------

	// bitwise reflected CRC-32: feedback bit taken per input bit
	function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		logic fb;
		r = c;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ b[k];
			r = r >> 1;
			if (fb)
				r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	// folding the case bit maps both letter ranges onto a..z and nothing else
	function automatic bit is_alpha(input logic [7:0] b);
		logic [7:0] f;
		f = b | CASE_BIT;
		return (f >= LOWER_A) && (f <= LOWER_Z);
	endfunction

	function automatic logic [7:0] magic_byte(input int i);
		return PNG_MAGIC[63 - 8*i -: 8];
	endfunction

	function automatic void start_chunk();
		ph = PH_LEN;
		cnt = '0;
		len_r = '0;
		typ_r = '0;
		rcrc = '0;
		ccrc = CRC_INIT;
	endfunction

	task automatic raise_error(input logic [2:0] code);
		chunk_result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.err = code;
		expected_results.push_back(r);
		halted = 1'b1;
	endtask

	// one accepted beat: advance the shadow parser, queue whatever result it causes
	task automatic deframe_step(input logic [7:0] b, input logic eos);
		chunk_result_t r;
		logic [31:0] fin;
		r = '0;
		if (halted)
			return;
		if (eos) begin
			// end of stream is only clean on a chunk boundary or before the signature
			if ((ph == PH_SIG || ph == PH_LEN) && cnt == 0) begin
				start_chunk();
				ph = PH_SIG;
			end else begin
				raise_error(ERR_TRUNCATED);
			end
			return;
		end
		case (ph)
			PH_SIG: begin
				if (b != magic_byte(cnt[2:0])) begin
					raise_error(ERR_SIGNATURE);
				end else begin
					cnt++;
					if (cnt == 8)
						start_chunk();
				end
			end
			PH_LEN: begin
				len_r = {len_r[23:0], b};
				cnt++;
				if (cnt == 4) begin
					if (chk_len && len_r[31]) begin
						raise_error(ERR_LENGTH);
					end else begin
						ph = PH_TYPE;
						cnt = '0;
					end
				end
			end
			PH_TYPE: begin
				if (chk_letters && !is_alpha(b)) begin
					raise_error(ERR_TYPE_CHAR);
				end else begin
					typ_r = {typ_r[23:0], b};
					ccrc = crc32_update(ccrc, b);
					cnt++;
					if (cnt == 4) begin
						// zero length: CRC follows the type directly
						ph = (len_r == 0) ? PH_CRC : PH_DATA;
						cnt = '0;
					end
				end
			end
			PH_DATA: begin
				ccrc = crc32_update(ccrc, b);
				cnt++;
				if (cnt >= len_r) begin
					ph = PH_CRC;
					cnt = '0;
				end
				if (pass_bytes) begin
					r.kind = KIND_DATA;
					r.data = b;
					expected_results.push_back(r);
				end
			end
			PH_CRC: begin
				rcrc = {rcrc[23:0], b};
				cnt++;
				if (cnt == 4) begin
					fin = ~ccrc;
					r.kind = KIND_SUMMARY;
					r.length = len_r;
					r.ctype = typ_r;
					r.iend = (typ_r == IEND_TYPE);
					if (!chk_crc)
						r.crc = CRC_NOT_CHECKED;
					else if (fin == rcrc)
						r.crc = CRC_MATCH;
					else
						r.crc = CRC_MISMATCH;
					if (chk_crc && fin != rcrc && !crc_flag) begin
						raise_error(ERR_CRC);
					end else begin
						expected_results.push_back(r);
						start_chunk();
					end
				end
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Driver: one beat per handshake, random gaps, valid held until taken
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			stream_if.valid <= 1'b0;
		end else begin
			if (stream_if.valid && stream_if.ready) begin
				deframe_step(stream_if.in_byte, stream_if.end_of_stream);
				void'(pending_beats.pop_front());
			end
			if (stream_if.valid && !stream_if.ready) begin
				// beat on offer but not taken: hold everything
			end else if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
				stream_if.valid <= 1'b1;
				stream_if.in_byte <= pending_beats[0].data;
				stream_if.end_of_stream <= pending_beats[0].eos;
			end else begin
				stream_if.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random backpressure, each result against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		chunk_result_t got, want;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				got.kind = result_if.result_kind;
				got.data = result_if.out_byte;
				got.length = result_if.chunk_length;
				got.ctype = result_if.chunk_tag;
				got.crc = result_if.crc_status;
				got.iend = result_if.is_end_chunk;
				got.err = result_if.error_code;
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result at %0t: kind=%0d byte=%02h len=%08h",
							$realtime, got.kind, got.data, got.length,
							" type=%08h crc=%0d end=%0d err=%0d",
							got.ctype, got.crc, got.iend, got.err);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.data !== want.data ||
							got.length !== want.length || got.ctype !== want.ctype ||
							got.crc !== want.crc || got.iend !== want.iend ||
							got.err !== want.err) begin
						if (mismatches < 10)
							$display("mismatch at %0t: exp kind=%0d byte=%02h len=%08h",
								$realtime, want.kind, want.data, want.length,
								" type=%08h crc=%0d end=%0d err=%0d",
								want.ctype, want.crc, want.iend, want.err,
								" | got kind=%0d byte=%02h len=%08h",
								got.kind, got.data, got.length,
								" type=%08h crc=%0d end=%0d err=%0d",
								got.ctype, got.crc, got.iend, got.err);
						mismatches++;
					end
				end
			end
			result_if.ready <= calm || ($urandom_range(0, 99) >= 31);
		end
	end

	// ---------------------------------------------------------------
	// Stream building
	// ---------------------------------------------------------------
	task automatic push_beat(input logic [7:0] b, input logic eos);
		pending_beats.push_back('{data: b, eos: eos});
		queued_beats++;
	endtask

	task automatic queue_signature();
		for (int i = 0; i < 8; i++)
			push_beat(magic_byte(i), 1'b0);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(UPPER_A, UPPER_Z));
		return 8'($urandom_range(LOWER_A, LOWER_Z));
	endfunction

	// mostly letters; arbitrary bytes mixed in when the letter check is off
	function automatic logic [31:0] pick_chunk_type();
		logic [31:0] t;
		t = '0;
		if ($urandom_range(0, 7) == 0)
			return IEND_TYPE;
		for (int i = 0; i < 4; i++) begin
			if (chk_letters || $urandom_range(0, 1))
				t = {t[23:0], rand_letter()};
			else
				t = {t[23:0], 8'($urandom_range(0, 255))};
		end
		return t;
	endfunction

	// small lengths keep a file short; one in twenty gets a longer body
	function automatic logic [31:0] pick_length();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(13, 48);
		return $urandom_range(0, 12);
	endfunction

	// length, type, random body, CRC over type and body (optionally spoiled)
	task automatic queue_chunk(input logic [31:0] len, input logic [31:0] ctype,
			input bit bad_crc);
		logic [31:0] crc;
		logic [7:0] b;
		crc = CRC_INIT;
		for (int i = 3; i >= 0; i--)
			push_beat(len[8*i +: 8], 1'b0);
		for (int i = 3; i >= 0; i--) begin
			push_beat(ctype[8*i +: 8], 1'b0);
			crc = crc32_update(crc, ctype[8*i +: 8]);
		end
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			push_beat(b, 1'b0);
			crc = crc32_update(crc, b);
		end
		crc = ~crc;
		if (bad_crc)
			crc = crc ^ ($urandom() | 32'd1);
		for (int i = 3; i >= 0; i--)
			push_beat(crc[8*i +: 8], 1'b0);
	endtask

	// well-formed file closed by end of stream; a bad CRC only where it is harmless
	task automatic queue_file();
		int n;
		n = $urandom_range(1, 4);
		queue_signature();
		repeat (n)
			queue_chunk(pick_length(), pick_chunk_type(),
				(!chk_crc || crc_flag) && $urandom_range(0, 2) == 0);
		push_beat(8'($urandom_range(0, 255)), 1'b1);
		// a second end of stream lands before any signature byte: also clean
		if ($urandom_range(0, 5) == 0)
			push_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// ---------------------------------------------------------------
	// Register writes, only with the block drained
	// ---------------------------------------------------------------
	task automatic wait_drained();
		while (pending_beats.size() != 0 || stream_if.valid || expected_results.size() != 0)
			@(posedge clk);
		// beats that cause nothing may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		case (idx)
			CFG_CHECK_LENGTH:       chk_len = v;
			CFG_CHECK_TYPE_LETTERS: chk_letters = v;
			CFG_CHECK_CRC:          chk_crc = v;
			CFG_CRC_FLAG_ONLY:      crc_flag = v;
			CFG_PASS_DATA:          pass_bytes = v;
			default: ;
		endcase
	endtask

	// bit i of opts goes to register i
	task automatic apply_config(input logic [4:0] opts);
		write_reg(CFG_CHECK_LENGTH, opts[0]);
		write_reg(CFG_CHECK_TYPE_LETTERS, opts[1]);
		write_reg(CFG_CHECK_CRC, opts[2]);
		write_reg(CFG_CRC_FLAG_ONLY, opts[3]);
		write_reg(CFG_PASS_DATA, opts[4]);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [4:0] opts);
		int stop_at;
		wait_drained();
		apply_config(opts);
		stop_at = queued_beats + BEATS_PER_PHASE;
		while (queued_beats < stop_at)
			queue_file();
	endtask

	// the one fatal error of the run, then beats the halted block must swallow
	task automatic queue_fatal_tail();
		logic [2:0] code;
		logic [4:0] opts;
		logic [31:0] len;
		logic [7:0] b;
		int k, drop, pushed;
		bit huge;
		code = 3'($urandom_range(ERR_SIGNATURE, ERR_TRUNCATED));
		huge = $urandom_range(0, 1);
		opts = 5'($urandom_range(0, 31));
		case (code)
			ERR_LENGTH:    opts[0] = 1'b1;
			ERR_TYPE_CHAR: opts[1] = 1'b1;
			ERR_CRC: begin
				opts[2] = 1'b1;
				opts[3] = 1'b0;
			end
			ERR_TRUNCATED: if (huge) opts[0] = 1'b0;
			default: ;
		endcase
		wait_drained();
		apply_config(opts);
		case (code)
			ERR_SIGNATURE: begin
				k = $urandom_range(0, 7);
				for (int i = 0; i < k; i++)
					push_beat(magic_byte(i), 1'b0);
				push_beat(magic_byte(k) ^ 8'($urandom_range(1, 255)), 1'b0);
			end
			ERR_LENGTH: begin
				queue_signature();
				if ($urandom_range(0, 1))
					queue_chunk(pick_length(), pick_chunk_type(), 1'b0);
				push_beat(8'($urandom_range(128, 255)), 1'b0);
				repeat (3) push_beat(8'($urandom_range(0, 255)), 1'b0);
			end
			ERR_TYPE_CHAR: begin
				queue_signature();
				repeat (3) push_beat(8'h00, 1'b0);
				push_beat(8'($urandom_range(0, 12)), 1'b0);
				k = $urandom_range(0, 3);
				repeat (k) push_beat(rand_letter(), 1'b0);
				do
					b = 8'($urandom_range(0, 255));
				while (is_alpha(b));
				push_beat(b, 1'b0);
			end
			ERR_CRC: begin
				queue_signature();
				queue_chunk(pick_length(), pick_chunk_type(), 1'b1);
			end
			default: begin
				if (huge) begin
					// unchecked length: body far longer than the stream, cut in the data
					len = 32'h8000_0000 | $urandom();
					queue_signature();
					for (int i = 3; i >= 0; i--)
						push_beat(len[8*i +: 8], 1'b0);
					len = pick_chunk_type();
					for (int i = 3; i >= 0; i--)
						push_beat(len[8*i +: 8], 1'b0);
					repeat ($urandom_range(0, 6)) push_beat(8'($urandom_range(0, 255)), 1'b0);
				end else begin
					// cut anywhere short of a chunk boundary
					len = pick_length();
					pushed = 8 + 12 + len;
					queue_signature();
					queue_chunk(len, pick_chunk_type(), 1'b0);
					drop = $urandom_range(1, pushed - 1);
					if (pushed - drop == 8)
						drop++;
					repeat (drop) void'(pending_beats.pop_back());
				end
				push_beat(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
		repeat (20) push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
	endtask

	// ---------------------------------------------------------------
	// Sequence of the run
	// ---------------------------------------------------------------
	initial begin
		int waited;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		stream_if.valid = 1'b0;
		stream_if.in_byte = '0;
		stream_if.end_of_stream = 1'b0;
		result_if.ready = 1'b0;
		mismatches = 0;
		queued_beats = 0;
		calm = 1'b0;
		// options and parser as they come out of reset
		chk_len = 1'b1;
		chk_letters = 1'b1;
		chk_crc = 1'b1;
		crc_flag = 1'b0;
		pass_bytes = 1'b1;
		start_chunk();
		ph = PH_SIG;
		halted = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// write past the register list: must change nothing
		write_reg(CFG_UNUSED, 1'b1);
		@(posedge clk);
		wr_en <= 1'b0;

		// directed: end of stream before any byte, then a minimal file holding
		// only a zero-length IEND chunk, closed on its boundary
		push_beat(8'h00, 1'b1);
		queue_signature();
		queue_chunk(32'd0, IEND_TYPE, 1'b0);
		push_beat(8'hFF, 1'b1);

		// random files under a range of option settings, extremes first
		run_phase(5'b11111);
		run_phase(5'b00000);
		wait_drained();
		calm = 1'b1;
		run_phase(5'b10111);
		wait_drained();
		calm = 1'b0;
		repeat (4) run_phase(5'($urandom_range(0, 31)));

		// the block halts for good on an error, so that comes last
		queue_fatal_tail();

		waited = 0;
		while ((pending_beats.size() != 0 || expected_results.size() != 0) && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0 && pending_beats.size() == 0)
			$display("[png_chunk_deframer] OK");
		else
			$display("[png_chunk_deframer] ERROR");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[png_chunk_deframer] ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/pcd_pkg.sv
src/pcd_in_if.sv
src/pcd_out_if.sv
src/png_chunk_deframer.sv
tb/tb_png_chunk_deframer.sv
